FILE: src/first_fit_range_allocator_defines.svh
// Assertion macros for the first-fit range allocator.
// Included by the top level; relies on its clock and reset ports.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FFRA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define FFRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ffra_pkg.sv
// Shared types and constants of the first-fit range allocator.
// No dependencies; imported by the ALU, the top level, the checker and the testbench.
package ffra_pkg;

   localparam int OFFSET_W = 20;
   localparam int COUNT_W  = 21;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;

   localparam int DEF_CAPACITY   = 1048576;
   localparam int DEF_MAX_BLOCKS = 64;

   // Largest end a freed block can have: top offset plus top count
   localparam int FREE_MAX_END = ((1 << OFFSET_W) - 1) + ((1 << COUNT_W) - 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_RESET = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_DROPPED  = 2'd2
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic borrow;
      logic zero;
   } alu_flags_type;

endpackage

FILE: src/ffra_table.sv
// Free-block table storage: one offset/size pair per entry.
// One write port, one registered read port; no package dependency.
module ffra_table #(
   parameter int DEPTH = 64,
   parameter int VAL_W = 22,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [VAL_W-1:0] rd_off,
   output logic [VAL_W-1:0] rd_size,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [VAL_W-1:0] wr_off,
   input  logic [VAL_W-1:0] wr_size
);

   logic [2*VAL_W-1:0] mem_ff [DEPTH];
   logic [2*VAL_W-1:0] rd_data_ff;

   // Write one entry, read one entry; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_off, wr_size};
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_off  = rd_data_ff[2*VAL_W-1:VAL_W];
   assign rd_size = rd_data_ff[VAL_W-1:0];

endmodule

FILE: src/ffra_alu.sv
// Shared add/subtract unit with borrow and zero flags.
// Uses ffra_pkg for the operation code and the flag struct.
module ffra_alu import ffra_pkg::*; #(
   parameter int VAL_W = 22
) (
   input  alu_op_type       op,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output logic [VAL_W-1:0] res,
   output alu_flags_type    flags
);

   logic [VAL_W:0] wide;

   // Add or subtract with one extra bit for the borrow
   always_comb begin
      unique case (op)
         ALU_ADD: wide = {1'b0, a} + {1'b0, b};
         ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      endcase
   end

   assign res          = wide[VAL_W-1:0];
   assign flags.borrow = (op == ALU_SUB) && wide[VAL_W];
   assign flags.zero   = (wide[VAL_W-1:0] == '0);

endmodule

FILE: src/first_fit_range_allocator.sv
// Allocate scans the entries in order, then trims the front of the granted block, or moves
// every later entry down one place to remove an exact fit; a miss scans every entry. Free walks
// the table with the new block slotted in, merging in place; a full table runs a trial pass
// first, then redoes the walk or drops the block. Reset-with-count clamps; unused opcodes just respond.
// One request in flight: req_ready returns once the result enters the output register.
// Synchronous active-high reset; after reset the S_INIT state writes the initial block before idle.
module first_fit_range_allocator import ffra_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [OFFSET_W-1:0] req_free_offset,
   input  logic [COUNT_W-1:0]  req_unit_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OFFSET_W-1:0] rsp_alloc_offset,
   output logic [STATUS_W-1:0] rsp_status
);

`include "first_fit_range_allocator_defines.svh"

   localparam int MAX_END = (CAPACITY > FREE_MAX_END) ? CAPACITY : FREE_MAX_END;
   localparam int VAL_W   = $clog2(MAX_END + 1);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [VAL_W-1:0] CAP_V = VAL_W'(CAPACITY);
   localparam logic [CNT_W-1:0] MAX_V = CNT_W'(MAX_BLOCKS);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_A_RD, S_A_CMP, S_A_OFF, S_A_SIZE,
      S_SH_RD, S_SH_WR,
      S_F_RD, S_F_CHK, S_F_ADD, S_F_CMP, S_F_MRG, S_F_FLUSH,
      S_R_CLAMP, S_R_SIZE,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]    next_idx;
   logic                ins_pend_ff, ins_pend_in;
   logic                commit_ff, commit_in;
   logic                acc_valid_ff, acc_valid_in;
   logic [VAL_W-1:0]    acc_off_ff, acc_off_in;
   logic [VAL_W-1:0]    acc_size_ff, acc_size_in;
   logic [VAL_W-1:0]    acc_end_ff, acc_end_in;
   logic [VAL_W-1:0]    e_off_ff, e_off_in;
   logic [VAL_W-1:0]    e_size_ff, e_size_in;
   logic [VAL_W-1:0]    e_end_ff, e_end_in;
   logic [VAL_W-1:0]    free_off_ff, free_off_in;
   logic [VAL_W-1:0]    count_ff, count_in;
   logic [VAL_W-1:0]    tmp_ff, tmp_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   alu_op_type          alu_op;
   logic [VAL_W-1:0]    alu_a, alu_b, alu_res;
   alu_flags_type       alu_flags;

   logic                tbl_rd_en, tbl_we;
   logic [IDX_W-1:0]    tbl_rd_addr, tbl_wr_addr;
   logic [VAL_W-1:0]    tbl_rd_off, tbl_rd_size, tbl_wr_off, tbl_wr_size;

   ffra_alu #(.VAL_W(VAL_W)) u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .flags (alu_flags)
   );

   ffra_table #(.DEPTH(MAX_BLOCKS), .VAL_W(VAL_W)) u_table (
      .clock   (clock),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_off  (tbl_rd_off),
      .rd_size (tbl_rd_size),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_off  (tbl_wr_off),
      .wr_size (tbl_wr_size)
   );

   assign next_idx  = rd_idx_ff + 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: next state, ALU operands and table accesses
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      ins_pend_in   = ins_pend_ff;
      commit_in     = commit_ff;
      acc_valid_in  = acc_valid_ff;
      acc_off_in    = acc_off_ff;
      acc_size_in   = acc_size_ff;
      acc_end_in    = acc_end_ff;
      e_off_in      = e_off_ff;
      e_size_in     = e_size_ff;
      e_end_in      = e_end_ff;
      free_off_in   = free_off_ff;
      count_in      = count_ff;
      tmp_in        = tmp_ff;
      res_off_in    = res_off_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_off_in    = rsp_off_ff;
      rsp_status_in = rsp_status_ff;
      alu_op        = ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = rd_idx_ff[IDX_W-1:0];
      tbl_we        = 1'b0;
      tbl_wr_addr   = wr_idx_ff[IDX_W-1:0];
      tbl_wr_off    = '0;
      tbl_wr_size   = '0;

      unique case (state_ff)
         // Lay down one block covering the whole region
         S_INIT: begin
            tbl_we      = 1'b1;
            tbl_wr_addr = '0;
            tbl_wr_off  = '0;
            tbl_wr_size = CAP_V;
            total_in    = CNT_W'(1);
            state_in    = S_IDLE;
         end

         // Take a request and dispatch on its opcode
         S_IDLE: begin
            if (req_valid) begin
               free_off_in   = VAL_W'(req_free_offset);
               count_in      = VAL_W'(req_unit_count);
               res_off_in    = '0;
               res_status_in = ST_OK;
               rd_idx_in     = '0;
               wr_idx_in     = '0;
               acc_valid_in  = 1'b0;
               ins_pend_in   = 1'b1;
               commit_in     = (total_ff != MAX_V);
               unique case (opcode_type'(req_opcode))
                  OP_ALLOC: state_in = S_A_RD;
                  OP_FREE:  state_in = S_F_RD;
                  OP_RESET: state_in = S_R_CLAMP;
                  default:  state_in = S_DONE;
               endcase
            end
         end

         // Allocate: scan for the first block that is large enough
         S_A_RD: begin
            if (rd_idx_ff == total_ff) begin
               res_status_in = ST_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               tbl_rd_en = 1'b1;
               state_in  = S_A_CMP;
            end
         end

         S_A_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = tbl_rd_size;
            alu_b  = count_ff;
            if (alu_flags.borrow) begin
               rd_idx_in = next_idx;
               state_in  = S_A_RD;
            end else begin
               res_off_in = tbl_rd_off[OFFSET_W-1:0];
               state_in   = alu_flags.zero ? S_SH_RD : S_A_OFF;
            end
         end

         // Shrink the granted block from the front
         S_A_OFF: begin
            alu_op   = ALU_ADD;
            alu_a    = tbl_rd_off;
            alu_b    = count_ff;
            tmp_in   = alu_res;
            state_in = S_A_SIZE;
         end

         S_A_SIZE: begin
            alu_op      = ALU_SUB;
            alu_a       = tbl_rd_size;
            alu_b       = count_ff;
            tbl_we      = 1'b1;
            tbl_wr_addr = rd_idx_ff[IDX_W-1:0];
            tbl_wr_off  = tmp_ff;
            tbl_wr_size = alu_res;
            state_in    = S_DONE;
         end

         // Remove an exact fit: move later entries down one place
         S_SH_RD: begin
            if (next_idx == total_ff) begin
               total_in = total_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = next_idx[IDX_W-1:0];
               state_in    = S_SH_WR;
            end
         end

         S_SH_WR: begin
            tbl_we      = 1'b1;
            tbl_wr_addr = rd_idx_ff[IDX_W-1:0];
            tbl_wr_off  = tbl_rd_off;
            tbl_wr_size = tbl_rd_size;
            rd_idx_in   = next_idx;
            state_in    = S_SH_RD;
         end

         // Free: walk the table with the new block slotted in, merging in place
         S_F_RD: begin
            if (rd_idx_ff == total_ff) begin
               if (ins_pend_ff) begin
                  e_off_in    = free_off_ff;
                  e_size_in   = count_ff;
                  ins_pend_in = 1'b0;
                  state_in    = S_F_ADD;
               end else begin
                  state_in = S_F_FLUSH;
               end
            end else begin
               tbl_rd_en = 1'b1;
               state_in  = S_F_CHK;
            end
         end

         // New block goes ahead of the first entry not below its offset
         S_F_CHK: begin
            alu_op   = ALU_SUB;
            alu_a    = tbl_rd_off;
            alu_b    = free_off_ff;
            state_in = S_F_ADD;
            if (ins_pend_ff && !alu_flags.borrow) begin
               e_off_in    = free_off_ff;
               e_size_in   = count_ff;
               ins_pend_in = 1'b0;
            end else begin
               e_off_in  = tbl_rd_off;
               e_size_in = tbl_rd_size;
               rd_idx_in = next_idx;
            end
         end

         S_F_ADD: begin
            alu_op   = ALU_ADD;
            alu_a    = e_off_ff;
            alu_b    = e_size_ff;
            e_end_in = alu_res;
            state_in = S_F_CMP;
         end

         // Merge if the running block ends where this one starts, else emit it
         S_F_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = acc_end_ff;
            alu_b  = e_off_ff;
            if (acc_valid_ff && alu_flags.zero) begin
               state_in = S_F_MRG;
            end else begin
               if (acc_valid_ff) begin
                  tbl_we      = commit_ff;
                  tbl_wr_off  = acc_off_ff;
                  tbl_wr_size = acc_size_ff;
                  wr_idx_in   = wr_idx_ff + 1'b1;
               end
               acc_valid_in = 1'b1;
               acc_off_in   = e_off_ff;
               acc_size_in  = e_size_ff;
               acc_end_in   = e_end_ff;
               state_in     = S_F_RD;
            end
         end

         S_F_MRG: begin
            alu_op      = ALU_ADD;
            alu_a       = acc_size_ff;
            alu_b       = e_size_ff;
            acc_size_in = alu_res;
            acc_end_in  = e_end_ff;
            state_in    = S_F_RD;
         end

         // Emit the last block; a full-table trial pass decides drop or redo
         S_F_FLUSH: begin
            if (commit_ff) begin
               tbl_we      = 1'b1;
               tbl_wr_off  = acc_off_ff;
               tbl_wr_size = acc_size_ff;
               total_in    = wr_idx_ff + 1'b1;
               state_in    = S_DONE;
            end else if (wr_idx_ff < MAX_V) begin
               commit_in    = 1'b1;
               rd_idx_in    = '0;
               wr_idx_in    = '0;
               acc_valid_in = 1'b0;
               ins_pend_in  = 1'b1;
               state_in     = S_F_RD;
            end else begin
               res_status_in = ST_DROPPED;
               state_in      = S_DONE;
            end
         end

         // Reset with used count: clamp, then one block to the end
         S_R_CLAMP: begin
            alu_op   = ALU_SUB;
            alu_a    = CAP_V;
            alu_b    = count_ff;
            tmp_in   = alu_flags.borrow ? CAP_V : count_ff;
            state_in = S_R_SIZE;
         end

         S_R_SIZE: begin
            alu_op      = ALU_SUB;
            alu_a       = CAP_V;
            alu_b       = tmp_ff;
            tbl_we      = 1'b1;
            tbl_wr_addr = '0;
            tbl_wr_off  = tmp_ff;
            tbl_wr_size = alu_res;
            total_in    = CNT_W'(1);
            state_in    = S_DONE;
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = res_off_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      ins_pend_ff   <= ins_pend_in;
      commit_ff     <= commit_in;
      acc_valid_ff  <= acc_valid_in;
      acc_off_ff    <= acc_off_in;
      acc_size_ff   <= acc_size_in;
      acc_end_ff    <= acc_end_in;
      e_off_ff      <= e_off_in;
      e_size_ff     <= e_size_in;
      e_end_ff      <= e_end_in;
      free_off_ff   <= free_off_in;
      count_ff      <= count_in;
      tmp_ff        <= tmp_in;
      res_off_ff    <= res_off_in;
      res_status_ff <= res_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alloc_offset = rsp_off_ff;
   assign rsp_status       = rsp_status_ff;

   // A taken request keeps the block busy in the next cycle
   `FFRA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after request")
   // The in-place merge never overwrites an entry that is still unread
   `FFRA_ASSERT_NOW(a_merge_behind_read, tbl_we && (state_ff == S_F_CMP), wr_idx_ff < rd_idx_ff, "merge write overtook read")
   // Free writes stay inside the table
   `FFRA_ASSERT_NOW(a_free_wr_in_range, tbl_we && (state_ff == S_F_CMP || state_ff == S_F_FLUSH), wr_idx_ff < MAX_V, "free write beyond table")
   // A finished request waits while the output register is occupied
   `FFRA_ASSERT_NEXT(a_done_waits, (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready, state_ff == S_DONE, "result overran output")

endmodule

FILE: test/first_fit_range_allocator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the first-fit range allocator: mirrors the free table, predicts every
// response from the accepted requests and compares it with what the block returns.
// Depends on ffra_pkg for field widths, opcodes and status codes.
module first_fit_range_allocator_checker import ffra_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [OFFSET_W-1:0] req_free_offset,
   input  logic [COUNT_W-1:0]  req_unit_count,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [OFFSET_W-1:0] rsp_alloc_offset,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  mismatch_count,
   output int                  outstanding
);

   // Offsets and sizes are kept wider than the ports, as merges can grow them
   typedef logic [31:0] span_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      status_type          status;
   } outcome_type;

   span_type    blk_start [0:MAX_BLOCKS];
   span_type    blk_len   [0:MAX_BLOCKS];
   int          blk_used;
   outcome_type outcome_queue [$];
   int          errs = 0;

   // Close the gap left by entry pos
   function automatic void remove_block(int pos);
      for (int k = pos; k + 1 < blk_used; k++) begin
         blk_start[k] = blk_start[k + 1];
         blk_len[k]   = blk_len[k + 1];
      end
      blk_used--;
   endfunction

   // Fold every entry that ends exactly where the next one starts
   function automatic void merge_neighbors();
      int i;
      i = 0;
      while (i + 1 < blk_used) begin
         if (blk_start[i] + blk_len[i] == blk_start[i + 1]) begin
            blk_len[i] = blk_len[i] + blk_len[i + 1];
            remove_block(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   // Leave one free block from the clamped used count up to the end of the region
   function automatic void rebuild_table(logic [COUNT_W-1:0] used);
      span_type lim;
      lim = (span_type'(used) > span_type'(CAPACITY)) ? span_type'(CAPACITY)
                                                      : span_type'(used);
      for (int k = 0; k <= MAX_BLOCKS; k++) begin
         blk_start[k] = '0;
         blk_len[k]   = '0;
      end
      blk_start[0] = lim;
      blk_len[0]   = span_type'(CAPACITY) - lim;
      blk_used     = 1;
   endfunction

   // Grant the first block large enough, removing it or trimming its front
   function automatic outcome_type grant_first_fit(logic [COUNT_W-1:0] want);
      outcome_type res;
      res.offset = '0;
      res.status = ST_NO_SPACE;
      for (int i = 0; i < blk_used && i < MAX_BLOCKS; i++) begin
         if (blk_len[i] >= span_type'(want)) begin
            res.offset = blk_start[i][OFFSET_W-1:0];
            res.status = ST_OK;
            if (blk_len[i] == span_type'(want)) begin
               remove_block(i);
            end else begin
               blk_start[i] = blk_start[i] + span_type'(want);
               blk_len[i]   = blk_len[i] - span_type'(want);
            end
            return res;
         end
      end
      return res;
   endfunction

   // Insert in offset order, merge, and roll back if the table overflows
   function automatic status_type insert_freed(logic [OFFSET_W-1:0] off,
                                               logic [COUNT_W-1:0] cnt);
      span_type keep_start [0:MAX_BLOCKS];
      span_type keep_len   [0:MAX_BLOCKS];
      int       keep_used;
      int       pos;
      keep_start = blk_start;
      keep_len   = blk_len;
      keep_used  = blk_used;
      pos = 0;
      while (pos < blk_used && blk_start[pos] < span_type'(off)) pos++;
      for (int k = blk_used; k > pos; k--) begin
         blk_start[k] = blk_start[k - 1];
         blk_len[k]   = blk_len[k - 1];
      end
      blk_start[pos] = span_type'(off);
      blk_len[pos]   = span_type'(cnt);
      blk_used++;
      merge_neighbors();
      if (blk_used > MAX_BLOCKS) begin
         blk_start = keep_start;
         blk_len   = keep_len;
         blk_used  = keep_used;
         return ST_DROPPED;
      end
      return ST_OK;
   endfunction

   function automatic outcome_type predict_response(logic [OPCODE_W-1:0] op,
                                                    logic [OFFSET_W-1:0] off,
                                                    logic [COUNT_W-1:0] cnt);
      outcome_type res;
      res.offset = '0;
      res.status = ST_OK;
      case (op)
         OP_ALLOC: res = grant_first_fit(cnt);
         OP_FREE:  res.status = insert_freed(off, cnt);
         OP_RESET: rebuild_table(cnt);
         default:  res.status = ST_OK;
      endcase
      return res;
   endfunction

   // Compare the response first, then queue the prediction for a new request
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rebuild_table('0);
         outcome_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $display("%0t: response with no request waiting (offset %0d, status %0d)",
                        $time, rsp_alloc_offset, rsp_status);
               errs++;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_alloc_offset !== want.offset) begin
                  $display("%0t: alloc_offset expected %0d, actual %0d",
                           $time, want.offset, rsp_alloc_offset);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready)
            outcome_queue.insert(outcome_queue.size(),
                                 predict_response(req_opcode, req_free_offset,
                                                  req_unit_count));
      end
      mismatch_count <= errs;
      outstanding    <= outcome_queue.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the first-fit range allocator test: clock, reset, request stimulus and verdict.
// Depends on ffra_pkg, the allocator RTL and first_fit_range_allocator_checker.
module testbench;
   import ffra_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
   localparam logic [OFFSET_W-1:0] OFFSET_TOP = '1;
   localparam logic [COUNT_W-1:0]  COUNT_TOP  = '1;
   localparam logic [COUNT_W-1:0]  FULL_SPAN  = COUNT_W'(DEF_CAPACITY);
   localparam int RANDOM_ITEMS = 850;
   localparam int STALL_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 100;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [COUNT_W-1:0]  units;
   } sent_type;

   typedef struct {
      logic [OFFSET_W-1:0] base;
      logic [COUNT_W-1:0]  units;
   } grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_ALLOC;
   logic [OFFSET_W-1:0] req_free_offset = '0;
   logic [COUNT_W-1:0]  req_unit_count = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [OFFSET_W-1:0] rsp_alloc_offset;
   logic [STATUS_W-1:0] rsp_status;

   int        mismatch_count;
   int        outstanding;
   int        ready_left = 0;
   int        stall_cycles = 0;
   bit        steady = 1'b0;
   sent_type  sent_log [$];
   grant_type granted  [$];

   first_fit_range_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_free_offset  (req_free_offset),
      .req_unit_count   (req_unit_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alloc_offset (rsp_alloc_offset),
      .rsp_status       (rsp_status)
   );

   first_fit_range_allocator_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_free_offset  (req_free_offset),
      .req_unit_count   (req_unit_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alloc_offset (rsp_alloc_offset),
      .rsp_status       (rsp_status),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Toggle response ready in stretches: long high runs, short and long stalls
   always @(posedge clock) begin
      int r;
      if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_ready  <= 1'b1;
            ready_left <= $urandom_range(1, 30);
         end else if (r < 90) begin
            rsp_ready  <= 1'b0;
            ready_left <= $urandom_range(1, 3);
         end else begin
            rsp_ready  <= 1'b0;
            ready_left <= $urandom_range(10, 40);
         end
      end
   end

   // Track granted blocks so later frees return real allocations
   always @(posedge clock) begin
      sent_type  done;
      grant_type got;
      if (!reset && rsp_valid && rsp_ready && sent_log.size() != 0) begin
         done = sent_log.pop_front();
         if (done.op == OP_RESET) begin
            granted.delete();
         end else if (done.op == OP_ALLOC && rsp_status == ST_OK) begin
            got = '{rsp_alloc_offset, done.units};
            granted.insert(granted.size(), got);
         end
      end
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic int idle_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_units();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return COUNT_W'($urandom_range(1, 32));
      if (r < 95) return COUNT_W'($urandom_range(0, 4096));
      return COUNT_W'($urandom);
   endfunction

   // Present one request and hold it until accepted; valid stays high afterwards
   task automatic send_req(logic [OPCODE_W-1:0] op, logic [OFFSET_W-1:0] off,
                           logic [COUNT_W-1:0] cnt);
      int       gap;
      sent_type rec;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_free_offset <= off;
      req_unit_count  <= cnt;
      do @(posedge clock); while (!req_ready);
      rec = '{op, cnt};
      sent_log.insert(sent_log.size(), rec);
   endtask

   // Drop valid and wait until every response has come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      do @(posedge clock); while (sent_log.size() != 0);
   endtask

   initial begin
      int        issued;
      int        nalloc;
      int        j;
      int        r;
      bit        alternate;
      grant_type snap  [$];
      grant_type order [$];
      grant_type rest  [$];
      grant_type tmp;
      grant_type last_freed;
      logic [OPCODE_W-1:0] op;

      last_freed = '{'0, '0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, empty table, zero-size blocks, clamped reset
      send_req(OP_ALLOC, '0, '0);
      send_req(OP_ALLOC, '0, COUNT_W'(1));
      send_req(OP_ALLOC, OFFSET_TOP, COUNT_TOP);
      send_req(OP_ALLOC, '0, FULL_SPAN);
      send_req(OP_FREE, '0, COUNT_W'(1));
      send_req(OP_ALLOC, '0, FULL_SPAN);
      send_req(OP_ALLOC, '0, COUNT_W'(1));
      send_req(OP_ALLOC, '0, '0);
      send_req(OP_FREE, OFFSET_TOP, COUNT_TOP);
      send_req(OP_FREE, '0, '0);
      send_req(OP_ALLOC, '0, '0);
      send_req(OP_FREE, '0, COUNT_W'(OFFSET_TOP));
      send_req(OP_UNUSED, OFFSET_TOP, COUNT_TOP);
      send_req(OP_RESET, OFFSET_TOP, COUNT_TOP);
      send_req(OP_ALLOC, '0, '0);
      send_req(OP_ALLOC, '0, COUNT_W'(1));
      send_req(OP_RESET, '0, '0);
      send_req(OP_RESET, '0, FULL_SPAN);
      send_req(OP_RESET, '0, COUNT_W'(12345));
      send_req(OP_ALLOC, '0, COUNT_W'(100));
      send_req(OP_FREE, '0, COUNT_W'(12345));
      send_req(OP_FREE, OFFSET_W'(12345), COUNT_W'(100));
      send_req(OP_RESET, '0, '0);
      drain_requests();
      granted.delete();

      // Random: mostly allocate bursts followed by frees of the grants, some noise
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 1) == 1) begin
               if ($urandom_range(0, 4) != 0)
                  send_req(OP_RESET, OFFSET_W'($urandom), COUNT_W'($urandom_range(0, 65535)));
               else
                  send_req(OP_RESET, OFFSET_W'($urandom),
                           COUNT_W'($urandom_range(0, DEF_CAPACITY)));
               issued++;
            end
            nalloc = ($urandom_range(0, 9) < 3) ? $urandom_range(130, 160)
                                                : $urandom_range(8, 60);
            // Keep the burst and its frees within what is left of the run
            if (nalloc > (RANDOM_ITEMS - issued) / 2 + 1)
               nalloc = (RANDOM_ITEMS - issued) / 2 + 1;
            repeat (nalloc) begin
               send_req(OP_ALLOC, OFFSET_W'($urandom), pick_units());
               issued++;
            end
            drain_requests();

            // Usually free every other grant first to fragment the table, then the rest shuffled
            snap = granted;
            granted.delete();
            order.delete();
            rest.delete();
            alternate = ($urandom_range(0, 9) < 7);
            foreach (snap[i]) begin
               if (alternate && (i % 2 == 0)) order.insert(order.size(), snap[i]);
               else rest.insert(rest.size(), snap[i]);
            end
            for (int i = rest.size() - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = rest[i];
               rest[i] = rest[j];
               rest[j] = tmp;
            end
            order = {order, rest};
            foreach (order[i]) begin
               r = $urandom_range(0, 99);
               if (r < 8) begin
                  send_req(OP_ALLOC, OFFSET_W'($urandom), pick_units());
                  issued++;
               end else if (r < 11) begin
                  send_req(OP_FREE, last_freed.base, last_freed.units);
                  issued++;
               end else if (r < 13) begin
                  send_req(OP_FREE, OFFSET_W'($urandom), COUNT_W'($urandom_range(0, 64)));
                  issued++;
               end
               send_req(OP_FREE, order[i].base, order[i].units);
               last_freed = order[i];
               issued++;
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               op = OPCODE_W'($urandom_range(0, 3));
               send_req(op, OFFSET_W'($urandom), COUNT_W'($urandom));
               issued++;
            end
         end
      end

      // Wait for the last responses, then let the block settle
      req_valid <= 1'b0;
      while (outstanding != 0 || sent_log.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
